>>> rtl/tbs_pkg.sv
package tbs_pkg;

	localparam int VERTEX_COUNT   = 3;
	localparam int COMPONENT_BITS = 16;

	localparam int SLOT_W   = 2;
	localparam int FIELD_W  = 16;
	localparam int WEIGHT_W = 16;
	localparam int LIGHT_W  = 16;
	localparam int COLOR_W  = 8;
	localparam int INTEN_W  = 16;
	localparam int UNIT_W   = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// blended normal: sum of three CB x 16 products, scaled down by 2^15
	localparam int BLEND_W = (COMPONENT_BITS + 4 > LIGHT_W + 1) ? COMPONENT_BITS + 4 : LIGHT_W + 1;
	localparam int MUL_W   = BLEND_W + 1;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int ACC_W   = PROD_W + 2;
	localparam int SQ_W    = 2 * BLEND_W + 2;
	localparam int SQRT_STEPS = SQ_W / 2;
	localparam int LEN_W   = SQRT_STEPS;
	localparam int QUOT_W  = UNIT_W - 1;
	localparam int DIV_W   = LEN_W + QUOT_W;
	localparam int ITER_MAX = (SQRT_STEPS > QUOT_W) ? SQRT_STEPS : QUOT_W;
	localparam int ITER_W  = $clog2(ITER_MAX + 1);

	localparam int BLEND_SHIFT = 15;
	localparam int FRAC_SHIFT  = 14;
	localparam int DOT_SHIFT   = 13;
	localparam int COLOR_SHIFT = 15;

	localparam int INTEN_ONE = 32768;
	localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = 8'd255;

	localparam logic signed [LIGHT_W-1:0] LIGHT_X_RST = 16'sd0;
	localparam logic signed [LIGHT_W-1:0] LIGHT_Y_RST = 16'sd0;
	localparam logic signed [LIGHT_W-1:0] LIGHT_Z_RST = 16'sd16384;
	localparam logic [COLOR_W-1:0] BASE_RED_RST   = 8'd255;
	localparam logic [COLOR_W-1:0] BASE_GREEN_RST = 8'd128;
	localparam logic [COLOR_W-1:0] BASE_BLUE_RST  = 8'd0;

	localparam int BAND_TH_0 = 31130;
	localparam int BAND_TH_1 = 26215;
	localparam int BAND_TH_2 = 19661;
	localparam int BAND_TH_3 = 13108;
	localparam int BAND_TH_4 = 6554;
	localparam int BAND_LV_0 = 32768;
	localparam int BAND_LV_1 = 26214;
	localparam int BAND_LV_2 = 19661;
	localparam int BAND_LV_3 = 13107;
	localparam int BAND_LV_4 = 6554;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LIGHT_X    = 3'd0,
		REG_LIGHT_Y    = 3'd1,
		REG_LIGHT_Z    = 3'd2,
		REG_BASE_RED   = 3'd3,
		REG_BASE_GREEN = 3'd4,
		REG_BASE_BLUE  = 3'd5
	} reg_idx_t;

	typedef enum logic {
		FUNC_LOAD  = 1'b0,
		FUNC_SHADE = 1'b1
	} func_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] weight_c;
		logic [WEIGHT_W-1:0] weight_b;
		logic [WEIGHT_W-1:0] weight_a;
		logic [FIELD_W-1:0]  normal_z;
		logic [FIELD_W-1:0]  normal_y;
		logic [FIELD_W-1:0]  normal_x;
		logic [SLOT_W-1:0]   vertex_slot;
	} item_t;

	localparam int ITEM_W      = $bits(item_t);
	localparam int IN_TDATA_W  = ((ITEM_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = 4 * COLOR_W + INTEN_W;

	typedef enum logic [2:0] {
		MS_BLEND  = 3'b001,
		MS_SQUARE = 3'b010,
		MS_DOT    = 3'b100
	} msel_t;

	typedef struct packed {
		msel_t      msel;
		logic       capture;
		logic       store;
		logic       mul_en;
		logic       acc_en;
		logic       acc_clr;
		logic       blend_wr;
		logic       sqrt_init;
		logic       sqrt_step;
		logic       div_init;
		logic       div_step;
		logic       div_wr;
		logic       band_en;
		logic       zero;
		logic       out_load;
		logic       src;
		logic [1:0] vi;
		logic [1:0] ki;
	} cmd_t;

	typedef struct packed {
		logic len_zero;
		logic out_free;
	} status_t;

	function automatic logic [INTEN_W-1:0] band(input logic [INTEN_W:0] d);
		logic [INTEN_W-1:0] r;
		if (d >= (INTEN_W+1)'(BAND_TH_0))      r = INTEN_W'(BAND_LV_0);
		else if (d >= (INTEN_W+1)'(BAND_TH_1)) r = INTEN_W'(BAND_LV_1);
		else if (d >= (INTEN_W+1)'(BAND_TH_2)) r = INTEN_W'(BAND_LV_2);
		else if (d >= (INTEN_W+1)'(BAND_TH_3)) r = INTEN_W'(BAND_LV_3);
		else if (d >= (INTEN_W+1)'(BAND_TH_4)) r = INTEN_W'(BAND_LV_4);
		else                                   r = d[INTEN_W-1:0];
		return r;
	endfunction

endpackage

>>> rtl/tbs_ctrl.sv
module tbs_ctrl import tbs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_func,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_STORE = 9'b000000010,
		S_MUL   = 9'b000000100,
		S_ACC   = 9'b000001000,
		S_SQRT  = 9'b000010000,
		S_DINIT = 9'b000100000,
		S_DIV   = 9'b001000000,
		S_BAND  = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	typedef enum logic [2:0] {
		PH_BLEND = 3'b001,
		PH_NORM  = 3'b010,
		PH_DOT   = 3'b100
	} phase_t;

	state_t state_q, state_d;
	phase_t phase_q, phase_d;
	logic [1:0] vi_q, vi_d, ki_q, ki_d;
	logic src_q, src_d, zero_q, zero_d;
	logic [ITER_W-1:0] iter_q, iter_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_BLEND;
			vi_q    <= '0;
			ki_q    <= '0;
			src_q   <= 1'b0;
			zero_q  <= 1'b0;
			iter_q  <= '0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			vi_q    <= vi_d;
			ki_q    <= ki_d;
			src_q   <= src_d;
			zero_q  <= zero_d;
			iter_q  <= iter_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		vi_d    = vi_q;
		ki_d    = ki_q;
		src_d   = src_q;
		zero_d  = zero_q;
		iter_d  = iter_q;
		cmd     = '0;
		cmd.vi  = vi_q;
		cmd.ki  = ki_q;
		cmd.src = src_q;
		cmd.zero = zero_q;
		unique case (phase_q)
			PH_BLEND: cmd.msel = MS_BLEND;
			PH_NORM:  cmd.msel = MS_SQUARE;
			PH_DOT:   cmd.msel = MS_DOT;
			default:  cmd.msel = MS_BLEND;
		endcase

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (func_t'(in_func) == FUNC_LOAD) begin
						state_d = S_STORE;
					end else begin
						state_d = S_MUL;
						phase_d = PH_BLEND;
						vi_d    = '0;
						ki_d    = '0;
						src_d   = 1'b0;
						zero_d  = 1'b0;
					end
				end
			end
			S_STORE: begin
				cmd.store = 1'b1;
				state_d   = S_IDLE;
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = S_ACC;
			end
			S_ACC: begin
				cmd.acc_en  = 1'b1;
				cmd.acc_clr = (phase_q == PH_BLEND) ? (vi_q == 2'd0) : (ki_q == 2'd0);
				state_d     = S_MUL;
				unique case (phase_q)
					PH_BLEND: begin
						if (vi_q == 2'd2) begin
							cmd.blend_wr = 1'b1;
							vi_d = '0;
							if (ki_q == 2'd2) begin
								phase_d = PH_NORM;
								ki_d    = '0;
							end else begin
								ki_d = ki_q + 2'd1;
							end
						end else begin
							vi_d = vi_q + 2'd1;
						end
					end
					PH_NORM: begin
						if (ki_q == 2'd2) begin
							cmd.sqrt_init = 1'b1;
							iter_d  = '0;
							state_d = S_SQRT;
						end else begin
							ki_d = ki_q + 2'd1;
						end
					end
					PH_DOT: begin
						if (ki_q == 2'd2) begin
							state_d = S_BAND;
						end else begin
							ki_d = ki_q + 2'd1;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_SQRT: begin
				cmd.sqrt_step = 1'b1;
				iter_d = iter_q + 1'b1;
				if (iter_q == ITER_W'(SQRT_STEPS - 1)) begin
					ki_d    = '0;
					state_d = S_DINIT;
				end
			end
			S_DINIT: begin
				if (status.len_zero) begin
					// zero-length vector: intensity is zero
					zero_d  = 1'b1;
					state_d = S_BAND;
				end else begin
					cmd.div_init = 1'b1;
					iter_d  = '0;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				iter_d = iter_q + 1'b1;
				if (iter_q == ITER_W'(QUOT_W - 1)) begin
					cmd.div_wr = 1'b1;
					if (ki_q == 2'd2) begin
						ki_d    = '0;
						state_d = S_MUL;
						if (!src_q) begin
							src_d = 1'b1;
						end else begin
							phase_d = PH_DOT;
						end
					end else begin
						ki_d    = ki_q + 2'd1;
						state_d = S_DINIT;
					end
				end
			end
			S_BAND: begin
				cmd.band_en = 1'b1;
				state_d     = S_OUT;
			end
			S_OUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

>>> rtl/tbs_datapath.sv
module tbs_datapath import tbs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output status_t                status,
	input  logic [IN_TDATA_W-1:0]  in_data,
	input  logic                   cfg_wr,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_TDATA_W-1:0] out_data
);

	logic signed [LIGHT_W-1:0] light_x_q, light_y_q, light_z_q;
	logic [COLOR_W-1:0] base_red_q, base_green_q, base_blue_q;

	item_t item_q;
	logic signed [COMPONENT_BITS-1:0] norm_q [VERTEX_COUNT][3];
	logic signed [BLEND_W-1:0] blend_q [3];
	logic signed [BLEND_W-1:0] light_v [3];
	logic signed [UNIT_W-1:0]  unit_q [2][3];

	logic [WEIGHT_W-1:0] w_sel;
	logic signed [BLEND_W-1:0] vec_sel;
	logic signed [MUL_W-1:0] ma, mb;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0] acc_q, acc_base, acc_new;

	logic [SQ_W-1:0] rem_q, res_q, bit_q, trial;

	logic [DIV_W-1:0] rdiv_q, dsh_q;
	logic [QUOT_W-1:0] quot_q, quot_nx;
	logic neg_q, ge;
	logic [BLEND_W-1:0] mag;
	logic [UNIT_W-1:0] uq;

	logic signed [ACC_W-1:0] dshift;
	logic [INTEN_W:0] dclamp;
	logic [INTEN_W-1:0] inten_q;

	logic [COLOR_W+INTEN_W-1:0] pr_r, pr_g, pr_b;
	logic [COLOR_W-1:0] red_q, green_q, blue_q;
	logic [INTEN_W-1:0] inten_out_q;
	logic out_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_x_q    <= LIGHT_X_RST;
			light_y_q    <= LIGHT_Y_RST;
			light_z_q    <= LIGHT_Z_RST;
			base_red_q   <= BASE_RED_RST;
			base_green_q <= BASE_GREEN_RST;
			base_blue_q  <= BASE_BLUE_RST;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_LIGHT_X:    light_x_q    <= cfg_data;
				REG_LIGHT_Y:    light_y_q    <= cfg_data;
				REG_LIGHT_Z:    light_z_q    <= cfg_data;
				REG_BASE_RED:   base_red_q   <= cfg_data[COLOR_W-1:0];
				REG_BASE_GREEN: base_green_q <= cfg_data[COLOR_W-1:0];
				REG_BASE_BLUE:  base_blue_q  <= cfg_data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= item_t'(in_data[ITEM_W-1:0]);
	end

	// vertex normal store, slot 3 ignored
	always_ff @(posedge clk) begin
		if (cmd.store && (item_q.vertex_slot < SLOT_W'(VERTEX_COUNT))) begin
			norm_q[item_q.vertex_slot][0] <= COMPONENT_BITS'(item_q.normal_x);
			norm_q[item_q.vertex_slot][1] <= COMPONENT_BITS'(item_q.normal_y);
			norm_q[item_q.vertex_slot][2] <= COMPONENT_BITS'(item_q.normal_z);
		end
	end

	assign light_v[0] = BLEND_W'(light_x_q);
	assign light_v[1] = BLEND_W'(light_y_q);
	assign light_v[2] = BLEND_W'(light_z_q);

	always_comb begin
		unique case (cmd.vi)
			2'd0:    w_sel = item_q.weight_a;
			2'd1:    w_sel = item_q.weight_b;
			default: w_sel = item_q.weight_c;
		endcase
	end

	assign vec_sel = cmd.src ? light_v[cmd.ki] : blend_q[cmd.ki];

	// shared multiplier
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (cmd.msel)
			MS_BLEND: begin
				ma = MUL_W'(norm_q[cmd.vi][cmd.ki]);
				mb = $signed(MUL_W'(w_sel));
			end
			MS_SQUARE: begin
				ma = MUL_W'(vec_sel);
				mb = MUL_W'(vec_sel);
			end
			MS_DOT: begin
				ma = MUL_W'(unit_q[0][cmd.ki]);
				mb = MUL_W'(unit_q[1][cmd.ki]);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) prod_q <= ma * mb;
	end

	always_comb begin
		if (cmd.acc_clr) acc_base = '0;
		else             acc_base = acc_q;
		acc_new = acc_base + ACC_W'(prod_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_en) acc_q <= acc_new;
		if (cmd.blend_wr) blend_q[cmd.ki] <= BLEND_W'(acc_new >>> BLEND_SHIFT);
	end

	// bit-pair square root
	assign trial = res_q + bit_q;

	always_ff @(posedge clk) begin
		if (cmd.sqrt_init) begin
			rem_q <= acc_new[SQ_W-1:0];
			res_q <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (cmd.sqrt_step) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign status.len_zero = (res_q == '0);

	// restoring divide of |v| * 2^14 by the length, truncated toward zero
	assign mag     = vec_sel[BLEND_W-1] ? BLEND_W'(-vec_sel) : BLEND_W'(vec_sel);
	assign ge      = (rdiv_q >= dsh_q);
	assign quot_nx = {quot_q[QUOT_W-2:0], ge};
	assign uq      = {1'b0, quot_nx};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			neg_q  <= vec_sel[BLEND_W-1];
			rdiv_q <= DIV_W'(mag) << FRAC_SHIFT;
			dsh_q  <= DIV_W'(res_q[LEN_W-1:0]) << (QUOT_W - 1);
			quot_q <= '0;
		end else if (cmd.div_step) begin
			if (ge) rdiv_q <= rdiv_q - dsh_q;
			dsh_q  <= dsh_q >> 1;
			quot_q <= quot_nx;
		end
		if (cmd.div_wr) unit_q[cmd.src][cmd.ki] <= neg_q ? $signed(-uq) : $signed(uq);
	end

	// clamp and band the dot product
	assign dshift = acc_q >>> DOT_SHIFT;

	always_comb begin
		if (dshift[ACC_W-1])                     dclamp = '0;
		else if (dshift > ACC_W'(INTEN_ONE))     dclamp = (INTEN_W+1)'(INTEN_ONE);
		else                                     dclamp = dshift[INTEN_W:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.band_en) inten_q <= cmd.zero ? '0 : band(dclamp);
	end

	// color scaling and output register
	assign pr_r = (COLOR_W+INTEN_W)'(base_red_q)   * (COLOR_W+INTEN_W)'(inten_q);
	assign pr_g = (COLOR_W+INTEN_W)'(base_green_q) * (COLOR_W+INTEN_W)'(inten_q);
	assign pr_b = (COLOR_W+INTEN_W)'(base_blue_q)  * (COLOR_W+INTEN_W)'(inten_q);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			red_q       <= pr_r[COLOR_SHIFT+COLOR_W-1:COLOR_SHIFT];
			green_q     <= pr_g[COLOR_SHIFT+COLOR_W-1:COLOR_SHIFT];
			blue_q      <= pr_b[COLOR_SHIFT+COLOR_W-1:COLOR_SHIFT];
			inten_out_q <= inten_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = {inten_out_q, ALPHA_OPAQUE, blue_q, green_q, red_q};

endmodule

>>> rtl/toon_band_shader_unit.sv
// Channel  | Direction | Handshake                | Payload
// s_*      | in        | s_tvalid / s_tready      | s_tdata item fields, s_tuser func
// m_*      | out       | m_tvalid / m_tready      | m_tdata shaded pixel
// cfg_*    | in        | cfg_valid / cfg_ready    | cfg_index register, cfg_data value
//
// Load transaction: accept, then store into the slot registers; no output.
// Shade transaction: blend the three vertex normals, then per vector (blended normal, then
//   light) square the components, take a bit-pair square root and do three restoring
//   divides; then the dot product, band and output. Root and divide run iteratively.
//   A zero-length vector exits early.
// Reset (arst_n low) clears control and output valid and sets config registers to their
//   reset values; normals are undefined until loaded.
// The output register holds a result until m_tready; a new transaction is accepted
//   meanwhile, and the block stalls only when the next result is ready to load.
module toon_band_shader_unit import tbs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [1:0] vertex_slot, [17:2] normal_x, [33:18] normal_y, [49:34] normal_z,
	// [65:50] weight_a, [81:66] weight_b, [97:82] weight_c, rest zero
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// [0] func
	input  logic                   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [47:32] intensity
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cmd_t    cmd;
	status_t status;

	// config writes are always taken
	assign cfg_ready = 1'b1;

	tbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_func  (s_tuser),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	tbs_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (s_tdata),
		.cfg_wr    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule
